/* src/midpoint_ellipse_rasterizer_unit_macros.svh */
// ----------------------------------------------------------------------------
// Midpoint ellipse rasterizer assertion macros
// Concurrent assertion wrappers used by the rasterizer top level.
// ----------------------------------------------------------------------------
`ifndef MIDPOINT_ELLIPSE_RASTERIZER_UNIT_MACROS_SVH
`define MIDPOINT_ELLIPSE_RASTERIZER_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define MER_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
`define MER_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define MER_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define MER_ASSERT_NXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

/* src/mer_pkg.sv */
// ----------------------------------------------------------------------------
// Midpoint ellipse rasterizer package
// Widths, register indexes, datapath operations and the command and status
// bundles shared by the controller and the datapath.
// ----------------------------------------------------------------------------
package mer_pkg;

	localparam int COORD_W    = 8;
	localparam int RAD_W      = 5;
	localparam int OUT_W      = 10;
	localparam int MASK_W     = 4;
	localparam int SCR_W      = 9;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 9;
	localparam int OFS_W      = 7;
	localparam int SQ_W       = 2 * RAD_W;
	localparam int MUL_W      = 12;
	localparam int PROD_W     = 2 * MUL_W;
	localparam int DEC_W      = 24;
	localparam int SLOPE_W    = 18;

	localparam int MAX_RADIUS   = 31;
	localparam int RESULT_CAP   = 64;
	localparam int CNT_W        = $clog2(RESULT_CAP + 1);
	localparam int SCREEN_RESET = 20;

	localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH  = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = CFG_IDX_W'(1);

	typedef enum logic [3:0] {
		DP_NOP,
		DP_LOAD,
		DP_SQUARE,
		DP_R1_MUL,
		DP_R1_LOAD,
		DP_R2_M0,
		DP_R2_M1,
		DP_R2_M2,
		DP_R2_M3,
		DP_R2_M4,
		DP_R2_LOAD,
		DP_STEP_R1,
		DP_STEP_R2
	} dp_op_t;

	typedef struct packed {
		dp_op_t op;
		logic   last;
	} cmd_t;

	typedef struct packed {
		logic r1_cont;
		logic y_zero;
		logic y_neg;
		logic n_last;
		logic cap_hit;
		logic out_free;
	} status_t;

	function automatic logic on_screen(
		input logic signed [OUT_W-1:0] x,
		input logic signed [OUT_W-1:0] y,
		input logic [SCR_W-1:0] w,
		input logic [SCR_W-1:0] h
	);
		logic x_ok;
		logic y_ok;
		x_ok = !x[OUT_W-1] && ($unsigned(x) < OUT_W'(w));
		y_ok = !y[OUT_W-1] && ($unsigned(y) < OUT_W'(h));
		return x_ok && y_ok;
	endfunction

endpackage

/* src/midpoint_ellipse_rasterizer_unit.sv */
// A new command is accepted only once the sequencer is back in idle after the
// previous command has issued its last result.
// Reset: arst_n clears the sequencer and the output valid at once and loads
// both screen registers with 20.
// ----------------------------------------------------------------------------
// Midpoint ellipse rasterizer top level
// Takes ellipse commands and streams the mirrored point sets of the
// two-region midpoint loop with an on-screen mask for each point.
// ----------------------------------------------------------------------------
`include "midpoint_ellipse_rasterizer_unit_macros.svh"

module midpoint_ellipse_rasterizer_unit (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   cfg_write_en,
	input  logic [mer_pkg::CFG_IDX_W-1:0]          cfg_index,
	input  logic [mer_pkg::CFG_DATA_W-1:0]         cfg_data,
	input  logic                                   in_valid,
	output logic                                   in_ready,
	input  logic [mer_pkg::COORD_W-1:0]            center_x,
	input  logic [mer_pkg::COORD_W-1:0]            center_y,
	input  logic [mer_pkg::RAD_W-1:0]              radius_x,
	input  logic [mer_pkg::RAD_W-1:0]              radius_y,
	output logic                                   out_valid,
	input  logic                                   out_ready,
	output logic signed [mer_pkg::OUT_W-1:0]       x_right,
	output logic signed [mer_pkg::OUT_W-1:0]       x_left,
	output logic signed [mer_pkg::OUT_W-1:0]       y_upper,
	output logic signed [mer_pkg::OUT_W-1:0]       y_lower,
	output logic [mer_pkg::MASK_W-1:0]             visible_mask,
	output logic                                   last_point
);
	import mer_pkg::*;

	cmd_t    cmd;
	status_t status;

	mer_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.status   (status),
		.cmd      (cmd)
	);

	mer_datapath u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.status       (status),
		.cfg_write_en (cfg_write_en),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.center_x     (center_x),
		.center_y     (center_y),
		.radius_x     (radius_x),
		.radius_y     (radius_y),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.x_right      (x_right),
		.x_left       (x_left),
		.y_upper      (y_upper),
		.y_lower      (y_lower),
		.visible_mask (visible_mask),
		.last_point   (last_point)
	);

	`MER_ASSERT_NXT(a_busy_after_in, clk, arst_n, in_valid && in_ready, !in_ready, "Block accepted a command while busy.")
	`MER_ASSERT_NXT(a_idle_quiet, clk, arst_n, !out_valid && in_ready, !out_valid, "Result produced while idle.")
	`MER_ASSERT_IMP(a_mask_ru, clk, arst_n, out_valid && visible_mask[0], !x_right[OUT_W-1] && !y_upper[OUT_W-1], "Visible point has a negative coordinate.")
	`MER_ASSERT_IMP(a_mask_ll, clk, arst_n, out_valid && visible_mask[3], !x_left[OUT_W-1] && !y_lower[OUT_W-1], "Visible point has a negative coordinate.")

endmodule

/* src/mer_datapath.sv */
// ----------------------------------------------------------------------------
// Midpoint ellipse rasterizer datapath
// Holds the command, the decision and slope registers, a shared multiplier
// for the region setup, the screen registers and the result register.
// ----------------------------------------------------------------------------
module mer_datapath (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  mer_pkg::cmd_t                          cmd,
	output mer_pkg::status_t                       status,
	input  logic                                   cfg_write_en,
	input  logic [mer_pkg::CFG_IDX_W-1:0]          cfg_index,
	input  logic [mer_pkg::CFG_DATA_W-1:0]         cfg_data,
	input  logic [mer_pkg::COORD_W-1:0]            center_x,
	input  logic [mer_pkg::COORD_W-1:0]            center_y,
	input  logic [mer_pkg::RAD_W-1:0]              radius_x,
	input  logic [mer_pkg::RAD_W-1:0]              radius_y,
	output logic                                   out_valid,
	input  logic                                   out_ready,
	output logic signed [mer_pkg::OUT_W-1:0]       x_right,
	output logic signed [mer_pkg::OUT_W-1:0]       x_left,
	output logic signed [mer_pkg::OUT_W-1:0]       y_upper,
	output logic signed [mer_pkg::OUT_W-1:0]       y_lower,
	output logic [mer_pkg::MASK_W-1:0]             visible_mask,
	output logic                                   last_point
);
	import mer_pkg::*;

	logic [COORD_W-1:0]        cx_q, cy_q;
	logic [RAD_W-1:0]          rx_q, ry_q;
	logic [SQ_W-1:0]           rx2_q, ry2_q;
	logic [PROD_W-1:0]         prod_q;
	logic signed [DEC_W-1:0]   dec_q;
	logic signed [SLOPE_W-1:0] sx_q, sy_q;
	logic [OFS_W-1:0]          ox_q;
	logic signed [OFS_W-1:0]   oy_q;
	logic [CNT_W-1:0]          cnt_q;
	logic [SCR_W-1:0]          scr_w_q, scr_h_q;
	logic                      out_valid_q;
	logic signed [OUT_W-1:0]   x_right_q, x_left_q, y_upper_q, y_lower_q;
	logic [MASK_W-1:0]         mask_q;
	logic                      last_q;

	logic [RAD_W-1:0]          rx_sat, ry_sat;
	logic [MUL_W-1:0]          mul_a, mul_b;
	logic [PROD_W-1:0]         mul_p;
	logic [OFS_W-1:0]          ym1_abs;
	logic signed [SLOPE_W-1:0] two_rx2_s, two_ry2_s, sx_inc, sy_dec;
	logic signed [DEC_W-1:0]   rx2_d, ry2_d, sx_inc_d, sy_dec_d, prod_d;
	logic signed [DEC_W-1:0]   dec_r1, dec_r2;
	logic signed [OUT_W-1:0]   xr, xl, yu, yl;
	logic                      emit;

	assign rx_sat = (RAD_W'(MAX_RADIUS) < radius_x) ? RAD_W'(MAX_RADIUS) : radius_x;
	assign ry_sat = (RAD_W'(MAX_RADIUS) < radius_y) ? RAD_W'(MAX_RADIUS) : radius_y;

	assign ym1_abs = (oy_q == '0) ? OFS_W'(1) : OFS_W'($unsigned(oy_q) - OFS_W'(1));

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (cmd.op)
			DP_R1_MUL: begin
				mul_a = MUL_W'(rx2_q);
				mul_b = MUL_W'(ry_q);
			end
			DP_R2_M0: begin
				mul_a = MUL_W'(ox_q);
				mul_b = MUL_W'(ox_q) + MUL_W'(1);
			end
			DP_R2_M1: begin
				mul_a = MUL_W'(ry2_q);
				mul_b = prod_q[MUL_W-1:0];
			end
			DP_R2_M2: begin
				mul_a = MUL_W'(ym1_abs);
				mul_b = MUL_W'(ym1_abs);
			end
			DP_R2_M3: begin
				mul_a = MUL_W'(rx2_q);
				mul_b = prod_q[MUL_W-1:0];
			end
			DP_R2_M4: begin
				mul_a = MUL_W'(rx2_q);
				mul_b = MUL_W'(ry2_q);
			end
			default: begin
			end
		endcase
	end

	assign mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);

	assign two_rx2_s = signed'(SLOPE_W'({rx2_q, 1'b0}));
	assign two_ry2_s = signed'(SLOPE_W'({ry2_q, 1'b0}));
	assign sx_inc    = sx_q + two_ry2_s;
	assign sy_dec    = sy_q - two_rx2_s;
	assign rx2_d     = signed'(DEC_W'(rx2_q));
	assign ry2_d     = signed'(DEC_W'(ry2_q));
	assign sx_inc_d  = DEC_W'(sx_inc);
	assign sy_dec_d  = DEC_W'(sy_dec);
	assign prod_d    = signed'(prod_q);

	assign dec_r1 = (dec_q < 0) ? dec_q + ry2_d + sx_inc_d
	                            : dec_q + ry2_d + sx_inc_d - sy_dec_d;
	assign dec_r2 = (dec_q > 0) ? dec_q + rx2_d - sy_dec_d
	                            : dec_q + rx2_d - sy_dec_d + sx_inc_d;

	assign xr = signed'(OUT_W'(cx_q)) + signed'(OUT_W'(ox_q));
	assign xl = signed'(OUT_W'(cx_q)) - signed'(OUT_W'(ox_q));
	assign yu = signed'(OUT_W'(cy_q)) + OUT_W'(oy_q);
	assign yl = signed'(OUT_W'(cy_q)) - OUT_W'(oy_q);

	assign emit = (cmd.op == DP_STEP_R1) || (cmd.op == DP_STEP_R2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scr_w_q     <= SCR_W'(SCREEN_RESET);
			scr_h_q     <= SCR_W'(SCREEN_RESET);
			out_valid_q <= 1'b0;
			cnt_q       <= '0;
		end else begin
			if (cfg_write_en) begin
				case (cfg_index)
					REG_SCREEN_WIDTH:  scr_w_q <= cfg_data;
					REG_SCREEN_HEIGHT: scr_h_q <= cfg_data;
					default: begin
					end
				endcase
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (cmd.op == DP_LOAD) begin
				cnt_q <= '0;
			end else if (emit) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		prod_q <= mul_p;
		case (cmd.op)
			DP_LOAD: begin
				cx_q <= center_x;
				cy_q <= center_y;
				rx_q <= rx_sat;
				ry_q <= ry_sat;
				ox_q <= '0;
				oy_q <= signed'(OFS_W'(ry_sat));
				sx_q <= '0;
			end
			DP_SQUARE: begin
				rx2_q <= SQ_W'(rx_q) * SQ_W'(rx_q);
				ry2_q <= SQ_W'(ry_q) * SQ_W'(ry_q);
			end
			DP_R1_LOAD: begin
				sy_q  <= signed'(SLOPE_W'({prod_q[SLOPE_W-2:0], 1'b0}));
				dec_q <= ry2_d - prod_d + signed'(DEC_W'(rx2_q >> 2));
			end
			DP_R2_M1: begin
				dec_q <= signed'(DEC_W'(ry2_q >> 2));
			end
			DP_R2_M2, DP_R2_M4: begin
				dec_q <= dec_q + prod_d;
			end
			DP_R2_LOAD: begin
				dec_q <= dec_q - prod_d;
			end
			DP_STEP_R1: begin
				ox_q  <= ox_q + OFS_W'(1);
				sx_q  <= sx_inc;
				dec_q <= dec_r1;
				if (!(dec_q < 0)) begin
					oy_q <= oy_q - OFS_W'(1);
					sy_q <= sy_dec;
				end
			end
			DP_STEP_R2: begin
				oy_q  <= oy_q - OFS_W'(1);
				sy_q  <= sy_dec;
				dec_q <= dec_r2;
				if (!(dec_q > 0)) begin
					ox_q <= ox_q + OFS_W'(1);
					sx_q <= sx_inc;
				end
			end
			default: begin
			end
		endcase
		if (emit) begin
			x_right_q <= xr;
			x_left_q  <= xl;
			y_upper_q <= yu;
			y_lower_q <= yl;
			mask_q    <= {on_screen(xl, yl, scr_w_q, scr_h_q),
			              on_screen(xr, yl, scr_w_q, scr_h_q),
			              on_screen(xl, yu, scr_w_q, scr_h_q),
			              on_screen(xr, yu, scr_w_q, scr_h_q)};
			last_q    <= cmd.last;
		end
	end

	assign status.r1_cont  = sx_q < sy_q;
	assign status.y_zero   = oy_q == '0;
	assign status.y_neg    = oy_q[OFS_W-1];
	assign status.n_last   = cnt_q == CNT_W'(RESULT_CAP - 1);
	assign status.cap_hit  = cnt_q == CNT_W'(RESULT_CAP);
	assign status.out_free = !out_valid_q || out_ready;

	assign out_valid    = out_valid_q;
	assign x_right      = x_right_q;
	assign x_left       = x_left_q;
	assign y_upper      = y_upper_q;
	assign y_lower      = y_lower_q;
	assign visible_mask = mask_q;
	assign last_point   = last_q;

endmodule

/* src/mer_ctrl.sv */
// ----------------------------------------------------------------------------
// Midpoint ellipse rasterizer controller
// Sequences command load, region setup multiplications and the two decision
// loops; issues one datapath op per cycle, no step while the output waits.
// ----------------------------------------------------------------------------
module mer_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  mer_pkg::status_t status,
	output mer_pkg::cmd_t    cmd
);
	import mer_pkg::*;

	typedef enum logic [11:0] {
		ST_IDLE    = 12'b0000_0000_0001,
		ST_SQUARE  = 12'b0000_0000_0010,
		ST_R1_MUL  = 12'b0000_0000_0100,
		ST_R1_LOAD = 12'b0000_0000_1000,
		ST_R1_RUN  = 12'b0000_0001_0000,
		ST_R2_M0   = 12'b0000_0010_0000,
		ST_R2_M1   = 12'b0000_0100_0000,
		ST_R2_M2   = 12'b0000_1000_0000,
		ST_R2_M3   = 12'b0001_0000_0000,
		ST_R2_M4   = 12'b0010_0000_0000,
		ST_R2_LOAD = 12'b0100_0000_0000,
		ST_R2_RUN  = 12'b1000_0000_0000
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		state_d  = state_q;
		cmd.op   = DP_NOP;
		cmd.last = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.op  = DP_LOAD;
					state_d = ST_SQUARE;
				end
			end
			ST_SQUARE: begin
				cmd.op  = DP_SQUARE;
				state_d = ST_R1_MUL;
			end
			ST_R1_MUL: begin
				cmd.op  = DP_R1_MUL;
				state_d = ST_R1_LOAD;
			end
			ST_R1_LOAD: begin
				cmd.op  = DP_R1_LOAD;
				state_d = ST_R1_RUN;
			end
			ST_R1_RUN: begin
				if (status.cap_hit) begin
					state_d = ST_IDLE;
				end else if (!status.r1_cont) begin
					state_d = ST_R2_M0;
				end else if (status.out_free) begin
					cmd.op   = DP_STEP_R1;
					cmd.last = status.n_last;
				end
			end
			ST_R2_M0: begin
				cmd.op  = DP_R2_M0;
				state_d = ST_R2_M1;
			end
			ST_R2_M1: begin
				cmd.op  = DP_R2_M1;
				state_d = ST_R2_M2;
			end
			ST_R2_M2: begin
				cmd.op  = DP_R2_M2;
				state_d = ST_R2_M3;
			end
			ST_R2_M3: begin
				cmd.op  = DP_R2_M3;
				state_d = ST_R2_M4;
			end
			ST_R2_M4: begin
				cmd.op  = DP_R2_M4;
				state_d = ST_R2_LOAD;
			end
			ST_R2_LOAD: begin
				cmd.op  = DP_R2_LOAD;
				state_d = ST_R2_RUN;
			end
			ST_R2_RUN: begin
				if (status.cap_hit || status.y_neg) begin
					state_d = ST_IDLE;
				end else if (status.out_free) begin
					cmd.op   = DP_STEP_R2;
					cmd.last = status.y_zero || status.n_last;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign in_ready = (state_q == ST_IDLE);

endmodule

/* test/tb_midpoint_ellipse_rasterizer_unit.sv */
// ----------------------------------------------------------------------------
// Midpoint ellipse rasterizer testbench
// Sends ellipse commands through the input handshake, predicts every mirrored
// point set with an independent integer model of the two-region midpoint loop,
// and compares each output transfer field by field while both sides stall at
// random, bar the last phase, and the screen size is changed between phases.
// ----------------------------------------------------------------------------
module tb_midpoint_ellipse_rasterizer_unit;
	timeunit 1ns;
	timeprecision 1ps;

	import mer_pkg::*;

	localparam int CYCLE_LIMIT = 1000000;
	localparam int HOLD_CYCLES = 400;
	localparam int SETTLE_CYCLES = 12;

	typedef struct {
		logic [COORD_W-1:0] cx;
		logic [COORD_W-1:0] cy;
		logic [RAD_W-1:0]   rx;
		logic [RAD_W-1:0]   ry;
	} ellipse_cmd_t;

	typedef struct {
		logic signed [OUT_W-1:0] xr;
		logic signed [OUT_W-1:0] xl;
		logic signed [OUT_W-1:0] yu;
		logic signed [OUT_W-1:0] yl;
		logic [MASK_W-1:0]       mask;
		logic                    last;
	} point_set_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_write_en = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [COORD_W-1:0] center_x = '0;
	logic [COORD_W-1:0] center_y = '0;
	logic [RAD_W-1:0] radius_x = '0;
	logic [RAD_W-1:0] radius_y = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [OUT_W-1:0] x_right;
	logic signed [OUT_W-1:0] x_left;
	logic signed [OUT_W-1:0] y_upper;
	logic signed [OUT_W-1:0] y_lower;
	logic [MASK_W-1:0] visible_mask;
	logic last_point;

	ellipse_cmd_t pending_cmds[$];
	point_set_t expected_points[$];
	int screen_w = SCREEN_RESET;
	int screen_h = SCREEN_RESET;
	int issued_cnt = 0;
	int accepted_cnt = 0;
	int err_cnt = 0;
	int cycle_cnt = 0;
	int hold_req = 0;
	int hold_seen = 0;
	int hold_left = 0;
	int stall_left = 0;
	int gap_left = 0;
	bit cmd_taken = 1'b0;
	bit quiet = 1'b0;
	ellipse_cmd_t next_cmd;
	point_set_t got;

	midpoint_ellipse_rasterizer_unit uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_write_en(cfg_write_en),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.center_x(center_x),
		.center_y(center_y),
		.radius_x(radius_x),
		.radius_y(radius_y),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.x_right(x_right),
		.x_left(x_left),
		.y_upper(y_upper),
		.y_lower(y_lower),
		.visible_mask(visible_mask),
		.last_point(last_point)
	);

	always #1 clk = ~clk;

	function automatic bit visible(int x, int y);
		return x >= 0 && x < screen_w && y >= 0 && y < screen_h;
	endfunction

	function automatic point_set_t mirror_points(int cx, int cy, int ox, int oy);
		point_set_t p;
		p.xr = OUT_W'(cx + ox);
		p.xl = OUT_W'(cx - ox);
		p.yu = OUT_W'(cy + oy);
		p.yl = OUT_W'(cy - oy);
		p.mask = {visible(cx - ox, cy - oy), visible(cx + ox, cy - oy),
			visible(cx - ox, cy + oy), visible(cx + ox, cy + oy)};
		p.last = 1'b0;
		return p;
	endfunction

	function automatic void trace_ellipse(input ellipse_cmd_t c);
		int cx;
		int cy;
		int rx;
		int ry;
		int rx2;
		int ry2;
		int ox;
		int oy;
		int d;
		int sx;
		int sy;
		int ym1;
		int n;
		point_set_t p;
		cx = c.cx;
		cy = c.cy;
		rx = (c.rx > MAX_RADIUS) ? MAX_RADIUS : c.rx;
		ry = (c.ry > MAX_RADIUS) ? MAX_RADIUS : c.ry;
		rx2 = rx * rx;
		ry2 = ry * ry;
		ox = 0;
		oy = ry;
		sx = 0;
		sy = 2 * rx2 * ry;
		n = 0;
		d = ry2 - rx2 * ry + (rx2 >>> 2);
		while (sx < sy && n < RESULT_CAP) begin
			expected_points.push_back(mirror_points(cx, cy, ox, oy));
			n++;
			ox++;
			sx += 2 * ry2;
			if (d < 0) begin
				d += ry2 + sx;
			end else begin
				oy--;
				sy -= 2 * rx2;
				d += ry2 + sx - sy;
			end
		end
		ym1 = oy - 1;
		d = ry2 * (ox * ox + ox) + (ry2 >>> 2) + rx2 * ym1 * ym1 - rx2 * ry2;
		while (oy >= 0 && n < RESULT_CAP) begin
			expected_points.push_back(mirror_points(cx, cy, ox, oy));
			n++;
			oy--;
			sy -= 2 * rx2;
			if (d > 0) begin
				d += rx2 - sy;
			end else begin
				ox++;
				sx += 2 * ry2;
				d += rx2 - sy + sx;
			end
		end
		if (n > 0) begin
			p = expected_points.pop_back();
			p.last = 1'b1;
			expected_points.push_back(p);
		end
	endfunction

	function automatic void check_field(string name, int exp_val, int act_val);
		if (exp_val != act_val) begin
			$error("%s mismatch: expected %0d, got %0d", name, exp_val, act_val);
			err_cnt++;
		end
	endfunction

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// Output check runs ahead of the input capture so that a transfer on both
	// sides in the same cycle is handled the same way in any event order.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (expected_points.size() == 0) begin
				$error("unexpected output transfer: x_right %0d y_upper %0d",
					x_right, y_upper);
				err_cnt++;
			end else begin
				got = expected_points.pop_front();
				check_field("x_right", got.xr, x_right);
				check_field("x_left", got.xl, x_left);
				check_field("y_upper", got.yu, y_upper);
				check_field("y_lower", got.yl, y_lower);
				check_field("visible_mask", got.mask, visible_mask);
				check_field("last_point", got.last, last_point);
			end
		end
		if (arst_n && in_valid && in_ready) begin
			trace_ellipse('{center_x, center_y, radius_x, radius_y});
			accepted_cnt++;
			cmd_taken = 1'b1;
		end
	end

	always @(negedge clk) begin
		if (in_valid && !cmd_taken) begin
			// Hold the offered command until its transfer.
		end else if (gap_left > 0) begin
			gap_left--;
			in_valid <= 1'b0;
		end else if (arst_n && pending_cmds.size() > 0) begin
			next_cmd = pending_cmds.pop_front();
			center_x <= next_cmd.cx;
			center_y <= next_cmd.cy;
			radius_x <= next_cmd.rx;
			radius_y <= next_cmd.ry;
			in_valid <= 1'b1;
			if (!quiet && $urandom_range(0, 4) == 0)
				gap_left = $urandom_range(1, 6);
		end else begin
			in_valid <= 1'b0;
		end
		cmd_taken = 1'b0;
	end

	always @(negedge clk) begin
		if (hold_req != hold_seen) begin
			hold_seen = hold_req;
			hold_left = HOLD_CYCLES;
		end
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left--;
			out_ready <= 1'b0;
		end else if (!quiet && $urandom_range(0, 7) == 0) begin
			stall_left = $urandom_range(1, 6) - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int val);
		@(negedge clk);
		cfg_write_en = 1'b1;
		cfg_index = idx;
		cfg_data = CFG_DATA_W'(val);
		@(negedge clk);
		cfg_write_en = 1'b0;
	endtask

	task automatic set_screen(int w, int h);
		write_reg(REG_SCREEN_WIDTH, w);
		screen_w = w & 9'h1FF;
		write_reg(REG_SCREEN_HEIGHT, h);
		screen_h = h & 9'h1FF;
	endtask

	task automatic send(int cx, int cy, int rx, int ry);
		pending_cmds.push_back('{COORD_W'(cx), COORD_W'(cy), RAD_W'(rx), RAD_W'(ry)});
		issued_cnt++;
	endtask

	task automatic send_random(int count);
		int cx_hi;
		int cy_hi;
		cx_hi = (screen_w > 255) ? 255 : screen_w;
		cy_hi = (screen_h > 255) ? 255 : screen_h;
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(0, 2) == 0)
				send($urandom_range(0, 255), $urandom_range(0, 255),
					$urandom_range(0, 31), $urandom_range(0, 31));
			else if ($urandom_range(0, 3) == 0)
				send($urandom_range(0, cx_hi), $urandom_range(0, cy_hi),
					$urandom_range(0, 3), $urandom_range(0, 3));
			else
				send($urandom_range(0, cx_hi), $urandom_range(0, cy_hi),
					$urandom_range(0, 31), $urandom_range(0, 31));
		end
	endtask

	task automatic drain();
		wait (accepted_cnt == issued_cnt && expected_points.size() == 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	initial begin
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		send(0, 0, 0, 0);
		send(255, 255, 31, 31);
		send(0, 255, 31, 0);
		send(255, 0, 0, 31);
		send(10, 10, 0, 0);
		send(10, 10, 31, 31);
		send(10, 10, 5, 3);
		send(10, 10, 3, 5);
		send(19, 19, 1, 1);
		send(0, 0, 31, 31);
		send(170, 85, 21, 10);
		send(85, 170, 10, 21);
		send(128, 128, 16, 16);
		send(5, 15, 31, 1);
		send(15, 5, 1, 31);
		send(20, 20, 2, 7);
		send(9, 12, 0, 6);
		send(12, 9, 6, 0);
		drain();

		set_screen(0, 0);
		send_random(20);
		drain();

		set_screen(511, 511);
		send(255, 255, 31, 31);
		send(0, 0, 31, 31);
		send_random(18);
		drain();

		set_screen(256, 256);
		hold_req++;
		send_random(12);
		drain();

		set_screen(1, 1);
		send(0, 0, 0, 0);
		send(0, 0, 1, 1);
		send_random(18);
		drain();

		for (int k = 0; k < 3; k++) begin
			set_screen($urandom_range(1, 256), $urandom_range(1, 256));
			send_random(25);
			drain();
		end

		quiet = 1'b1;
		set_screen(20, 32);
		send_random(30);
		drain();

		if (err_cnt == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
